@@ design/partial_track_lifecycle_macros.svh @@
// ----------------------------------------------------------------------------
// partial_track_lifecycle_macros
// assertion macros used by the checker file of the track lifecycle block
// ----------------------------------------------------------------------------
`ifndef PARTIAL_TRACK_LIFECYCLE_MACROS_SVH
`define PARTIAL_TRACK_LIFECYCLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PTL_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PTL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/ptl_pkg.sv @@
// ----------------------------------------------------------------------------
// ptl_pkg
// types, codes and defaults shared by the track lifecycle modules
// ----------------------------------------------------------------------------
package ptl_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CFG_BITS       = 8;
    localparam int CFG_IDX_BITS   = 1;

    // register indexes of the config port
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIRTH_NEEDED  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEATH_ALLOWED = 1'b1;

    // command codes carried in s_tuser
    localparam logic CMD_INIT   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [CFG_BITS-1:0] BIRTH_NEEDED_RST  = 8'd3;
    localparam logic [CFG_BITS-1:0] DEATH_ALLOWED_RST = 8'd3;

    typedef enum logic [1:0] {
        ST_DEAD  = 2'd0,
        ST_BIRTH = 2'd1,
        ST_ALIVE = 2'd2,
        ST_DYING = 2'd3
    } lifecycle_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] birth_needed;
        logic [CFG_BITS-1:0] death_allowed;
    } cfg_t;

endpackage

@@ design/ptl_in_stage.sv @@
// ----------------------------------------------------------------------------
// ptl_in_stage
// input register: holds one accepted item until the core takes it
// ----------------------------------------------------------------------------
module ptl_in_stage
    import ptl_pkg::*;
#(
    parameter int DATA_W = 104,
    parameter int USER_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [USER_W-1:0] s_tuser,
    input  logic              advance,
    output logic              item_valid,
    output logic [DATA_W-1:0] item_data,
    output logic [USER_W-1:0] item_user
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;
    logic [USER_W-1:0] user_reg;
    logic              load;

    // free when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= s_tdata;
            user_reg <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;
    assign item_user  = user_reg;

endmodule

@@ design/ptl_core.sv @@
// ----------------------------------------------------------------------------
// ptl_core
// lifecycle state machine, stored value words and frame counters
// ----------------------------------------------------------------------------
module ptl_core
    import ptl_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  cfg_t                  cfg,
    input  logic                  command,
    input  logic                  matched,
    input  logic [VALUE_BITS-1:0] amplitude_in,
    input  logic [VALUE_BITS-1:0] frequency_in,
    input  logic [VALUE_BITS-1:0] phase_in,
    output lifecycle_t            track_state,
    output logic                  is_active,
    output logic [VALUE_BITS-1:0] amplitude_out,
    output logic [VALUE_BITS-1:0] frequency_out,
    output logic [VALUE_BITS-1:0] phase_out,
    output logic [COUNT_BITS-1:0] alive_count,
    output logic [COUNT_BITS-1:0] longest_count,
    output logic                  misuse_error
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    lifecycle_t            state_reg, state_next;
    logic [VALUE_BITS-1:0] amp_reg, amp_next;
    logic [VALUE_BITS-1:0] freq_reg, freq_next;
    logic [VALUE_BITS-1:0] phase_reg, phase_next;
    logic [COUNT_BITS-1:0] alive_reg, alive_next;
    logic [COUNT_BITS-1:0] birth_reg, birth_next;
    logic [COUNT_BITS-1:0] dying_reg, dying_next;
    logic [COUNT_BITS-1:0] longest_reg, longest_next;
    logic                  err;
    logic [COUNT_BITS-1:0] birth_inc;
    logic [COUNT_BITS-1:0] dying_inc;
    logic [COUNT_BITS-1:0] alive_inc;
    logic [COUNT_BITS-1:0] birth_thr;
    logic [COUNT_BITS-1:0] death_thr;

    // saturating increments
    assign birth_inc = (birth_reg == COUNT_MAX) ? COUNT_MAX : birth_reg + 1'b1;
    assign dying_inc = (dying_reg == COUNT_MAX) ? COUNT_MAX : dying_reg + 1'b1;
    assign alive_inc = (alive_reg == COUNT_MAX) ? COUNT_MAX : alive_reg + 1'b1;
    assign birth_thr = COUNT_BITS'(cfg.birth_needed);
    assign death_thr = COUNT_BITS'(cfg.death_allowed);

    always_comb
    begin
        state_next   = state_reg;
        amp_next     = amp_reg;
        freq_next    = freq_reg;
        phase_next   = phase_reg;
        alive_next   = alive_reg;
        birth_next   = birth_reg;
        dying_next   = dying_reg;
        longest_next = longest_reg;
        err          = 1'b0;
        if (command == CMD_INIT)
        begin
            if (state_reg != ST_DEAD)
            begin
                err = 1'b1;
            end
            else
            begin
                amp_next   = amplitude_in;
                freq_next  = frequency_in;
                phase_next = phase_in;
                state_next = ST_BIRTH;
                alive_next = '0;
                birth_next = '0;
                dying_next = '0;
            end
        end
        else if (state_reg == ST_DEAD)
        begin
            err = 1'b1;
        end
        else if (matched)
        begin
            amp_next   = amplitude_in;
            freq_next  = frequency_in;
            phase_next = phase_in;
            alive_next = alive_inc;
            if (alive_inc > longest_reg)
            begin
                longest_next = alive_inc;
            end
            unique case (state_reg)
                ST_BIRTH:
                begin
                    birth_next = birth_inc;
                    if (birth_inc >= birth_thr)
                    begin
                        state_next = ST_ALIVE;
                    end
                end
                ST_DYING:
                begin
                    state_next = ST_ALIVE;
                    dying_next = '0;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        else
        begin
            unique case (state_reg)
                ST_BIRTH:
                begin
                    // failed birth keeps the alive count
                    state_next = ST_DEAD;
                end
                ST_DYING:
                begin
                    dying_next = dying_inc;
                    if (dying_inc >= death_thr)
                    begin
                        state_next = ST_DEAD;
                        alive_next = '0;
                    end
                end
                default:
                begin
                    state_next = ST_DYING;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_DEAD;
            amp_reg     <= '0;
            freq_reg    <= '0;
            phase_reg   <= '0;
            alive_reg   <= '0;
            birth_reg   <= '0;
            dying_reg   <= '0;
            longest_reg <= '0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            amp_reg     <= amp_next;
            freq_reg    <= freq_next;
            phase_reg   <= phase_next;
            alive_reg   <= alive_next;
            birth_reg   <= birth_next;
            dying_reg   <= dying_next;
            longest_reg <= longest_next;
        end
    end

    // the result shows the state after this item
    assign track_state   = state_next;
    assign is_active     = (state_next == ST_ALIVE) || (state_next == ST_DYING);
    assign amplitude_out = amp_next;
    assign frequency_out = freq_next;
    assign phase_out     = phase_next;
    assign alive_count   = alive_next;
    assign longest_count = longest_next;
    assign misuse_error  = err;

endmodule

@@ design/ptl_out_stage.sv @@
// ----------------------------------------------------------------------------
// ptl_out_stage
// result register: holds one result until the receiver takes it
// ----------------------------------------------------------------------------
module ptl_out_stage
    import ptl_pkg::*;
#(
    parameter int DATA_W = 136,
    parameter int USER_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [DATA_W-1:0] res_data,
    input  logic [USER_W-1:0] res_user,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic [USER_W-1:0] m_tuser
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;
    logic [USER_W-1:0] user_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_data;
            user_reg <= res_user;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

@@ design/partial_track_lifecycle.sv @@
// ----------------------------------------------------------------------------
// partial_track_lifecycle
// birth / alive / dying / dead tracker for one sinusoidal analysis track
// ----------------------------------------------------------------------------
// usage
//   s_* carries items: tuser is the command (init or frame update), tdata the
//   matched flag and the amplitude, frequency and phase words
//   m_* carries one result per item: the state after the item, stored words,
//   frame counts in tdata, and the misuse flag in tuser
//   cfg_we / cfg_index / cfg_data write the birth and death thresholds; the user
//   must write them only while no item is in flight, the block does not enforce it
// flow
//   an accepted item sits in the input register, and the lifecycle logic feeds
//   the result register once that register can load
//   1 item per cycle sustained while the receiver takes results; the state
//   registers close their loop so each item sees the state the previous one left
// reset
//   rst_n clears both stage valids, puts the track dead with zeroed words and
//   counters, and loads both thresholds with 3
// stall
//   a stalled receiver holds the result register; one more item waits in the
//   input register, then s_tready drops until the result is taken
// ----------------------------------------------------------------------------
module partial_track_lifecycle
    import ptl_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int IN_BITS   = 1 + 3 * VALUE_BITS,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 3 + 3 * VALUE_BITS + 2 * COUNT_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // config write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    // input items
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // matched, amplitude_in, frequency_in, phase_in, zero pad
    input  logic [IN_W-1:0]         s_tdata,
    // command
    input  logic [0:0]              s_tuser,
    // results
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // track_state, is_active, amplitude_out, frequency_out, phase_out,
    // alive_count, longest_count, zero pad
    output logic [OUT_W-1:0]        m_tdata,
    // misuse_error
    output logic [0:0]              m_tuser
);

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;

    logic                  item_valid;
    logic [IN_W-1:0]       item_data;
    logic [0:0]            item_user;
    logic                  can_load;
    logic                  fire;

    lifecycle_t            res_state;
    logic                  res_active;
    logic [VALUE_BITS-1:0] res_amp;
    logic [VALUE_BITS-1:0] res_freq;
    logic [VALUE_BITS-1:0] res_phase;
    logic [COUNT_BITS-1:0] res_alive;
    logic [COUNT_BITS-1:0] res_longest;
    logic                  res_err;
    logic [OUT_W-1:0]      res_data;

    // threshold registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIRTH_NEEDED:  cfg_next.birth_needed  = cfg_data;
                CFG_DEATH_ALLOWED: cfg_next.death_allowed = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.birth_needed  <= BIRTH_NEEDED_RST;
            cfg_reg.death_allowed <= DEATH_ALLOWED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // an item moves through the core when the result register can take it
    assign fire = item_valid && can_load;

    ptl_in_stage #(
        .DATA_W (IN_W),
        .USER_W (1)
    ) u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (fire),
        .item_valid (item_valid),
        .item_data  (item_data),
        .item_user  (item_user)
    );

    ptl_core #(
        .COUNT_BITS (COUNT_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .cfg           (cfg_reg),
        .command       (item_user[0]),
        .matched       (item_data[0]),
        .amplitude_in  (item_data[1 +: VALUE_BITS]),
        .frequency_in  (item_data[1 + VALUE_BITS +: VALUE_BITS]),
        .phase_in      (item_data[1 + 2 * VALUE_BITS +: VALUE_BITS]),
        .track_state   (res_state),
        .is_active     (res_active),
        .amplitude_out (res_amp),
        .frequency_out (res_freq),
        .phase_out     (res_phase),
        .alive_count   (res_alive),
        .longest_count (res_longest),
        .misuse_error  (res_err)
    );

    // pack the result, lowest field first
    assign res_data = OUT_W'({res_longest, res_alive, res_phase, res_freq, res_amp,
                              res_active, res_state});

    ptl_out_stage #(
        .DATA_W (OUT_W),
        .USER_W (1)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res_data (res_data),
        .res_user (res_err),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ design/ptl_checker.sv @@
// ----------------------------------------------------------------------------
// ptl_checker
// port-level checks of the track lifecycle block, bound to the top level
// ----------------------------------------------------------------------------
`include "partial_track_lifecycle_macros.svh"

module ptl_checker
    import ptl_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int OUT_W     = ((3 + 3 * VALUE_BITS + 2 * COUNT_BITS + 7) / 8) * 8,
    localparam int ALIVE_LSB = 3 + 3 * VALUE_BITS,
    localparam int LONG_LSB  = ALIVE_LSB + COUNT_BITS
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [OUT_W-1:0]        m_tdata,
    input logic [0:0]              m_tuser
);

    // a stalled result holds its payload
    `PTL_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // active flag agrees with the reported state (alive or dying)
    `PTL_ASSERT_NOW(a_active, m_tvalid, m_tdata[2] == m_tdata[1], "is_active disagrees with track_state")

    // the longest run never falls below the current count
    `PTL_ASSERT_NOW(a_longest, m_tvalid, m_tdata[LONG_LSB +: COUNT_BITS] >= m_tdata[ALIVE_LSB +: COUNT_BITS], "longest_count below alive_count")

    // with the result side empty the input side always takes an item
    `PTL_ASSERT_NOW(a_ready, !m_tvalid, s_tready, "input not ready while result side empty")

endmodule

bind partial_track_lifecycle ptl_checker #(
    .COUNT_BITS (COUNT_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_ptl_checker (.*);
